[hw/rtl/crcdf_pkg.sv]
// Shared constants, codes and the CRC-16/XMODEM byte update for the packet deframer.
package crcdf_pkg;

    localparam int MAX_FRAME = 4096;
    localparam int MIN_FRAME = 5;
    localparam int LEN_W     = $clog2(MAX_FRAME + 1);
    localparam int LIMIT_W   = 12;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd4091;
    localparam logic [15:0]        CRC_POLY    = 16'h1021;

    localparam logic [1:0] KIND_ID   = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_CRC = 2'd2;
    localparam logic [1:0] ST_TOO_BIG = 2'd3;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/crc16_packet_deframer.sv]
// Length-prefixed packet receiver with CRC-16/XMODEM check: top level.
//
// Takes one received serial byte per request on the s_ side and parses packets
// laid out as: 16-bit big-endian total length L (counting every byte), a frame
// id byte, L-5 payload bytes, and a big-endian CRC-16/XMODEM (poly 0x1021,
// init 0) over all bytes ahead of the CRC. For each packet the m_ side gives a
// frame id request, one request per payload byte, and an end request carrying
// the status (ok, bad length, CRC mismatch, payload over payload_limit).
// A length above 4096 or below 5 ends the frame at once with bad length on the
// length low byte and parsing restarts at the next byte. Payload bytes are
// dropped when L-5 exceeds payload_limit; CRC mismatch wins over oversize.
// Rate: one byte per clock, sustained. The parse state and the result register
// both update in the cycle a byte is taken, so a result appears in the cycle after
// its byte; s_tready drops only while the result register is full and the
// downstream side is stalling. Write payload_limit only while idle.
module crc16_packet_deframer
(
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration: payload_limit
    input  logic                          cfg_we,
    input  logic [crcdf_pkg::LIMIT_W-1:0] cfg_wdata,

    // received bytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte

    // parsed results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [7:0] value, [9:8] status, rest zero
    output logic [1:0]                    m_tuser    // [1:0] kind
);
    import crcdf_pkg::*;

    // parse phase codes
    localparam logic [1:0] PH_LEN_HI = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_CRC    = 2'd3;

    logic [LIMIT_W-1:0] limit_reg;

    logic [1:0]       phase_reg,    phase_next;
    logic [LEN_W-1:0] idx_reg,      idx_next;
    logic [7:0]       len_hi_reg,   len_hi_next;
    logic [LEN_W-1:0] len_reg,      len_next;
    logic [15:0]      crc_reg,      crc_next;
    logic [7:0]       crc_hi_reg,   crc_hi_next;
    logic             oversize_reg, oversize_next;

    logic             out_valid_reg;
    logic [1:0]       kind_reg,   kind_next;
    logic [7:0]       value_reg,  value_next;
    logic [1:0]       status_reg, status_next;
    logic             emit;

    logic             take;
    logic [7:0]       rx_byte;
    logic [15:0]      crc_upd;
    logic [15:0]      full_len;
    logic [LEN_W-1:0] len_m2;
    logic [LEN_W-1:0] idx_p1;
    logic [LEN_W-1:0] data_len;

    assign rx_byte  = s_tdata;
    // result register frees up when empty or being drained this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    assign crc_upd     = crc16_byte((phase_reg == PH_LEN_HI) ? 16'h0000 : crc_reg, rx_byte);
    assign full_len    = {len_hi_reg, rx_byte};
    assign data_len    = full_len[LEN_W-1:0] - LEN_W'(MIN_FRAME);
    assign len_m2      = len_reg - LEN_W'(2);
    assign idx_p1      = idx_reg + LEN_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        len_hi_next   = len_hi_reg;
        len_next      = len_reg;
        crc_next      = crc_reg;
        crc_hi_next   = crc_hi_reg;
        oversize_next = oversize_reg;
        emit          = 1'b0;
        kind_next     = KIND_END;
        value_next    = 8'h00;
        status_next   = ST_OK;

        unique case (phase_reg)
            PH_LEN_HI:
            begin
                crc_next    = crc_upd;
                len_hi_next = rx_byte;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                crc_next = crc_upd;
                if (full_len > 16'(MAX_FRAME) || full_len < 16'(MIN_FRAME))
                begin
                    emit          = 1'b1;
                    kind_next     = KIND_END;
                    status_next   = ST_BAD_LEN;
                    oversize_next = 1'b0;
                    phase_next    = PH_LEN_HI;
                end
                else
                begin
                    len_next      = full_len[LEN_W-1:0];
                    oversize_next = data_len > {1'b0, limit_reg};
                    idx_next      = LEN_W'(2);
                    phase_next    = PH_BODY;
                end
            end
            PH_BODY:
            begin
                crc_next = crc_upd;
                idx_next = idx_p1;
                if (idx_p1 >= len_m2)
                begin
                    phase_next = PH_CRC;
                end
                // first body byte is the frame id
                if (idx_reg == LEN_W'(2))
                begin
                    emit       = 1'b1;
                    kind_next  = KIND_ID;
                    value_next = rx_byte;
                end
                else if (!oversize_reg)
                begin
                    emit       = 1'b1;
                    kind_next  = KIND_DATA;
                    value_next = rx_byte;
                end
            end
            PH_CRC:
            begin
                if (idx_reg == len_m2)
                begin
                    crc_hi_next = rx_byte;
                    idx_next    = idx_p1;
                end
                else
                begin
                    emit      = 1'b1;
                    kind_next = KIND_END;
                    if ({crc_hi_reg, rx_byte} != crc_reg)
                    begin
                        status_next = ST_BAD_CRC;
                    end
                    else if (oversize_reg)
                    begin
                        status_next = ST_TOO_BIG;
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                    oversize_next = 1'b0;
                    phase_next    = PH_LEN_HI;
                end
            end
            default:
            begin
                phase_next = PH_LEN_HI;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            phase_reg     <= PH_LEN_HI;
            oversize_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (take)
            begin
                phase_reg    <= phase_next;
                oversize_reg <= oversize_next;
            end
            if (take)
            begin
                out_valid_reg <= emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            idx_reg    <= idx_next;
            len_hi_reg <= len_hi_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            crc_hi_reg <= crc_hi_next;
            if (emit)
            begin
                kind_reg   <= kind_next;
                value_reg  <= value_next;
                status_reg <= status_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'b000000, status_reg, value_reg};

`ifndef SYNTHESIS
    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY || phase_reg == PH_CRC) |->
            (len_reg >= LEN_W'(MIN_FRAME) && len_reg <= LEN_W'(MAX_FRAME)))
        else $error("frame length out of range inside a frame");

    a_body_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> (idx_reg >= LEN_W'(2) && idx_reg < len_m2))
        else $error("body byte index outside payload span");

    a_end_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_END) |-> value_reg == 8'h00)
        else $error("end result carries nonzero value");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_END) |-> status_reg == ST_OK)
        else $error("status set on id or payload result");

    a_id_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == PH_BODY && idx_reg == LEN_W'(2)) |=>
            (out_valid_reg && kind_reg == KIND_ID))
        else $error("first body byte did not produce a frame id");
`endif

endmodule

[sim/crc16_packet_deframer_test.sv]
// Self-checking testbench for the length-prefixed CRC-16/XMODEM packet deframer.
module crc16_packet_deframer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import crcdf_pkg::*;

    // Watchdog: the whole run is roughly thirteen hundred bytes, each waiting
    // out at most a sender gap plus receiver stall bursts.
    localparam int CYCLE_LIMIT = 500_000;
    localparam int MAX_SHOWN   = 10;

    // One result request as seen on the m_ side.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [1:0] status;
    } frame_event_t;

    // Parser phases of the shadow model.
    typedef enum logic [1:0] {WAIT_LEN_HI, WAIT_LEN_LO, IN_BODY, IN_CRC} parse_phase_t;

    // Ways a sent frame can be damaged.
    typedef enum {FLAW_NONE, FLAW_CRC, FLAW_BODY} frame_flaw_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;    // [7:0] rx_byte
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [15:0]        m_tdata;    // [7:0] value, [9:8] status, [15:10] zero
    logic [1:0]         m_tuser;    // [1:0] kind

    // Shadow model of the parser.
    parse_phase_t       parse_phase = WAIT_LEN_HI;
    int                 byte_idx    = 0;
    int                 frame_len   = 0;
    logic [15:0]        run_crc     = '0;
    logic [7:0]         crc_hi      = '0;
    logic               too_big     = 1'b0;
    logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;

    frame_event_t       pending_results [$];
    logic [7:0]         fixed_payload [$];

    int                 mismatches  = 0;
    int                 bytes_sent  = 0;
    int                 cycle_count = 0;
    int                 gap_odds    = 0;    // 1-in-N chance of a sender gap, 0 = none
    int                 stall_odds  = 0;    // 1-in-N chance of a receiver stall, 0 = none
    int                 stall_left  = 0;

    crc16_packet_deframer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Bit-serial CRC-16/XMODEM, MSB first.
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic void queue_result(input logic [1:0] k, input logic [7:0] v,
                                         input logic [1:0] s);
        frame_event_t ev;
        ev.kind   = k;
        ev.value  = v;
        ev.status = s;
        pending_results.push_back(ev);
    endfunction

    // Back to hunting for a length header.
    function automatic void hunt_restart();
        parse_phase = WAIT_LEN_HI;
        byte_idx    = 0;
        frame_len   = 0;
        run_crc     = '0;
        crc_hi      = '0;
        too_big     = 1'b0;
    endfunction

    // Advances the shadow parser by one received byte and queues what it emits.
    function automatic void parse_rx_byte(input logic [7:0] b);
        logic [1:0] st;
        case (parse_phase)
            WAIT_LEN_HI:
            begin
                run_crc     = crc_add_byte(16'h0000, b);
                frame_len   = int'(b) << 8;
                byte_idx    = 1;
                parse_phase = WAIT_LEN_LO;
            end
            WAIT_LEN_LO:
            begin
                run_crc   = crc_add_byte(run_crc, b);
                frame_len = frame_len | int'(b);
                if (frame_len > MAX_FRAME || frame_len < MIN_FRAME)
                begin
                    hunt_restart();
                    queue_result(KIND_END, 8'h00, ST_BAD_LEN);
                end
                else
                begin
                    too_big     = (frame_len - MIN_FRAME) > int'(limit_shadow);
                    byte_idx    = 2;
                    parse_phase = IN_BODY;
                end
            end
            IN_BODY:
            begin
                run_crc = crc_add_byte(run_crc, b);
                if (byte_idx + 1 >= frame_len - 2)
                begin
                    parse_phase = IN_CRC;
                end
                // first body byte is the frame id; payload is dropped when over the limit
                if (byte_idx == 2)
                begin
                    queue_result(KIND_ID, b, ST_OK);
                end
                else if (!too_big)
                begin
                    queue_result(KIND_DATA, b, ST_OK);
                end
                byte_idx++;
            end
            default:
            begin
                if (byte_idx == frame_len - 2)
                begin
                    crc_hi = b;
                    byte_idx++;
                end
                else
                begin
                    // CRC mismatch wins over oversize
                    if ({crc_hi, b} != run_crc)
                    begin
                        st = ST_BAD_CRC;
                    end
                    else if (too_big)
                    begin
                        st = ST_TOO_BIG;
                    end
                    else
                    begin
                        st = ST_OK;
                    end
                    hunt_restart();
                    queue_result(KIND_END, 8'h00, st);
                end
            end
        endcase
    endfunction

    // Compares one accepted result request with the oldest expectation.
    function automatic void check_result();
        frame_event_t want;
        logic         bad;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
            begin
                $display("%0t: unexpected result kind %0d value %02h status %0d",
                         $time, m_tuser, m_tdata[7:0], m_tdata[9:8]);
            end
        end
        else
        begin
            want = pending_results.pop_front();
            bad  = 1'b0;
            if (m_tuser !== want.kind)         bad = 1'b1;
            if (m_tdata[7:0] !== want.value)   bad = 1'b1;
            if (m_tdata[9:8] !== want.status)  bad = 1'b1;
            if (m_tdata[15:10] !== 6'd0)       bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("%0t: expected kind %0d value %02h status %0d pad 00",
                             $time, want.kind, want.value, want.status);
                    $display("    got kind %0d value %02h status %0d pad %02h",
                             m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[15:10]);
                end
            end
        end
    endfunction

    // Everything is sampled at the rising edge. A byte taken at this edge is
    // parsed before the result check.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_restart();
            limit_shadow = LIMIT_RESET;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_rx_byte(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            if (cfg_we)
            begin
                limit_shadow = cfg_wdata;
            end
        end
    end

    // Receiver: random stall bursts, changed on the falling edge.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready = 1'b0;
            stall_left--;
        end
        else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(1, 7) - 1;
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** crc16_packet_deframer: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (all entered and left at a falling edge)
    // ------------------------------------------------------------------

    // Offers one byte, optionally after a gap, and holds it until taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            gap      = $urandom_range(1, 7);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    // Builds a packet of the given total length and sends it. Payload comes
    // from fixed_payload first, then random bytes. A flaw is applied after the
    // CRC is computed.
    task automatic send_frame(input int total, input logic [7:0] id, input frame_flaw_t flaw);
        logic [7:0]  pkt [$];
        logic [15:0] crc;
        int          k;
        int          pos;
        pkt.push_back(total[15:8]);
        pkt.push_back(total[7:0]);
        pkt.push_back(id);
        for (k = 0; k < total - 5; k++)
        begin
            if (fixed_payload.size() != 0)
            begin
                pkt.push_back(fixed_payload.pop_front());
            end
            else
            begin
                pkt.push_back(8'($urandom_range(0, 255)));
            end
        end
        crc = 16'h0000;
        foreach (pkt[i])
        begin
            crc = crc_add_byte(crc, pkt[i]);
        end
        pkt.push_back(crc[15:8]);
        pkt.push_back(crc[7:0]);
        if (flaw == FLAW_CRC)
        begin
            pos = total - 2 + $urandom_range(0, 1);
            pkt[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
        else if (flaw == FLAW_BODY)
        begin
            pos = $urandom_range(2, total - 3);
            pkt[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
        foreach (pkt[i])
        begin
            send_byte(pkt[i]);
        end
    endtask

    // Just a length header that is out of range.
    task automatic send_bad_length(input logic [15:0] total);
        send_byte(total[15:8]);
        send_byte(total[7:0]);
    endtask

    // Drops valid and waits out every expected result plus the pipeline.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_payload_limit(input logic [LIMIT_W-1:0] v);
        wait_idle();
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Mostly well-formed small frames; some damaged ones and bad headers.
    task automatic send_random_frame();
        int          r;
        int          total;
        logic [15:0] bad_len;
        r = $urandom_range(0, 19);
        if (r < 14)
        begin
            total = $urandom_range(5, 24);
        end
        else if (r < 19)
        begin
            total = $urandom_range(25, 120);
        end
        else
        begin
            total = $urandom_range(121, 400);
        end
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                bad_len = 16'($urandom_range(0, MIN_FRAME - 1));
            end
            else
            begin
                bad_len = 16'($urandom_range(MAX_FRAME + 1, 65535));
            end
            send_bad_length(bad_len);
        end
        else if (r == 1)
        begin
            send_frame(total, 8'($urandom_range(0, 255)), FLAW_CRC);
        end
        else if (r == 2)
        begin
            send_frame(total, 8'($urandom_range(0, 255)), FLAW_BODY);
        end
        else
        begin
            send_frame(total, 8'($urandom_range(0, 255)), FLAW_NONE);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Shortest frame (id only) and a frame with extreme id and payload bytes.
    task automatic test_basic_frames();
        send_frame(MIN_FRAME, 8'h00, FLAW_NONE);
        fixed_payload = '{8'h00, 8'hFF};
        send_frame(7, 8'hFF, FLAW_NONE);
    endtask

    // Totals below 5 and above 4096 end at once; hunting resumes right after.
    task automatic test_bad_lengths();
        send_bad_length(16'd0);
        send_bad_length(16'(MIN_FRAME - 1));
        send_bad_length(16'(MAX_FRAME + 1));
        send_bad_length(16'hFFFF);
    endtask

    task automatic test_crc_mismatch();
        send_frame(MIN_FRAME, 8'hA5, FLAW_CRC);
    endtask

    // Oversize around small limits, including oversize with a bad CRC.
    task automatic test_payload_limit();
        set_payload_limit('0);
        send_frame(MIN_FRAME, 8'h3C, FLAW_NONE);
        send_frame(MIN_FRAME + 1, 8'hC3, FLAW_NONE);
        send_frame(MIN_FRAME + 1, 8'h5A, FLAW_CRC);
        set_payload_limit(12'd7);
        send_frame(MIN_FRAME + 7, 8'h81, FLAW_NONE);
        send_frame(MIN_FRAME + 8, 8'h18, FLAW_NONE);
    endtask

    // Same payload length right at the limit and then one past it.
    task automatic test_limit_edges();
        set_payload_limit(12'd15);
        send_frame(MIN_FRAME + 15, 8'h7E, FLAW_NONE);
        set_payload_limit(12'd14);
        send_frame(MIN_FRAME + 15, 8'hE7, FLAW_NONE);
    endtask

    // Phases of random traffic, each under its own limit and idling mix.
    task automatic test_random_traffic();
        int stop_at;
        int phase_end;
        int r;
        stop_at = bytes_sent + 1000;
        while (bytes_sent < stop_at)
        begin
            case ($urandom_range(0, 3))
                0:       set_payload_limit('0);
                1:       set_payload_limit(12'd4091);
                2:       set_payload_limit(12'($urandom_range(0, 30)));
                default: set_payload_limit(12'($urandom_range(0, 4091)));
            endcase
            r          = $urandom_range(0, 3);
            gap_odds   = (r == 0) ? 0 : (1 << r);
            r          = $urandom_range(0, 3);
            stall_odds = (r == 0) ? 0 : (1 << r);
            phase_end  = bytes_sent + 150 + $urandom_range(0, 100);
            while (bytes_sent < phase_end && bytes_sent < stop_at)
            begin
                send_random_frame();
            end
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_quiet_tail();
        int stop_at;
        set_payload_limit(12'($urandom_range(0, 30)));
        gap_odds   = 0;
        stall_odds = 0;
        stop_at    = bytes_sent + 150;
        while (bytes_sent < stop_at)
        begin
            send_random_frame();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part runs with moderate idling on both sides
        gap_odds   = 4;
        stall_odds = 4;
        test_basic_frames();
        test_bad_lengths();
        test_crc_mismatch();
        test_payload_limit();
        test_limit_edges();
        test_random_traffic();
        test_quiet_tail();

        wait_idle();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("** crc16_packet_deframer: PASSED **");
        end
        else
        begin
            $display("** crc16_packet_deframer: FAILED **");
        end
        $finish;
    end

endmodule
